>>> design/csld_pkg.sv
// ----------------------------------------------------------------------------
// csld_pkg
// Shared types, constants and character helpers for the C string literal
// decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package csld_pkg;

  // Content length saturates at MaxLen + 1 (terminating zero included)
  localparam int unsigned MaxLen   = 4096;
  localparam int unsigned LenW     = 13;
  localparam int unsigned AccW     = 9;
  localparam int unsigned ResDepth = 4;
  localparam int unsigned ResPtrW  = $clog2(ResDepth);
  localparam int unsigned ResCntW  = ResPtrW + 1;

  typedef enum logic [2:0] {
    KIND_CONTENT  = 3'd0,
    KIND_END      = 3'd1,
    KIND_BAD_HEX  = 3'd2,
    KIND_HEX_OVF  = 3'd3,
    KIND_UNCLOSED = 3'd4
  } kind_e;

  typedef enum logic [4:0] {
    PH_PLAIN = 5'b00001,
    PH_ESC   = 5'b00010,
    PH_OCT   = 5'b00100,
    PH_HEX0  = 5'b01000,
    PH_HEX   = 5'b10000
  } phase_e;

  typedef struct packed {
    kind_e            kind;
    logic [7:0]       value;
    logic [LenW-1:0]  len;
    logic             last;
  } res_t;

  // Results produced by one accepted byte (zero, one or two)
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic logic is_oct(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h37);
  endfunction

  function automatic logic is_hexd(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h61) && (c <= 8'h66)) ||
           ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    if (c <= 8'h39) t = c - 8'h30;
    else if (c >= 8'h61) t = c - 8'h57;
    else t = c - 8'h37;
    return t[3:0];
  endfunction

  function automatic logic [7:0] simple_escape(input logic [7:0] c);
    logic [7:0] r;
    unique case (c)
      8'h61:   r = 8'd7;   // a
      8'h62:   r = 8'd8;   // b
      8'h74:   r = 8'd9;   // t
      8'h6e:   r = 8'd10;  // n
      8'h76:   r = 8'd11;  // v
      8'h66:   r = 8'd12;  // f
      8'h72:   r = 8'd13;  // r
      8'h65:   r = 8'd27;  // e
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/csld_decode.sv
// ----------------------------------------------------------------------------
// csld_decode
// Escape phase state and per-byte decode step; yields up to two results.
// ----------------------------------------------------------------------------
`default_nettype none

module csld_decode (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           accept_i,
  input  wire logic [7:0]     char_i,
  output csld_pkg::push_t     push_o
);
  import csld_pkg::*;

  typedef struct packed {
    logic            has;
    res_t            r;
    phase_e          ph;
    logic [LenW-1:0] bc;
  } plain_t;

  phase_e          phase_q, phase_d;
  logic [AccW-1:0] acc_q, acc_d;
  logic [1:0]      dcnt_q, dcnt_d;
  logic [LenW-1:0] bc_q, bc_d;

  res_t            r0, r1;
  logic [1:0]      n;
  logic [LenW-1:0] bc_inc;
  logic [AccW-1:0] oct_t;
  logic [11:0]     hex_t;
  plain_t          pl;

  function automatic logic [LenW-1:0] sat_inc(input logic [LenW-1:0] b);
    return (b < LenW'(MaxLen)) ? b + 1'b1 : b;
  endfunction

  // Byte handled outside any escape, with byte count b
  function automatic plain_t plain_step(input logic [7:0] c, input logic [LenW-1:0] b);
    plain_t p;
    p = '{has: 1'b0, r: '0, ph: PH_PLAIN, bc: b};
    if (c == 8'h22) begin
      p.has     = 1'b1;
      p.r.kind  = KIND_END;
      p.r.len   = b + 1'b1;
      p.bc      = '0;
    end else if (c == 8'h5c) begin
      p.ph      = PH_ESC;
    end else begin
      p.has     = 1'b1;
      p.r.kind  = KIND_CONTENT;
      p.r.value = c;
      p.bc      = sat_inc(b);
    end
    return p;
  endfunction

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    dcnt_d  = dcnt_q;
    bc_d    = bc_q;
    n       = 2'd0;
    r0      = '0;
    r1      = '0;
    bc_inc  = sat_inc(bc_q);
    oct_t   = {acc_q[AccW-4:0], 3'b000} + AccW'(char_i[2:0]);
    hex_t   = {acc_q[7:0], 4'b0000} + 12'(hex_val(char_i));
    pl      = plain_step(char_i, bc_q);

    if (char_i == 8'h00) begin
      // zero byte: unclosed, pending escape dropped
      n       = 2'd1;
      r0.kind = KIND_UNCLOSED;
      phase_d = PH_PLAIN;
      acc_d   = '0;
      dcnt_d  = '0;
      bc_d    = '0;
    end else begin
      unique case (phase_q)
        PH_ESC: begin
          if (is_oct(char_i)) begin
            acc_d   = AccW'(char_i[2:0]);
            dcnt_d  = 2'd1;
            phase_d = PH_OCT;
          end else if (char_i == 8'h78) begin
            acc_d   = '0;
            dcnt_d  = '0;
            phase_d = PH_HEX0;
          end else begin
            phase_d  = PH_PLAIN;
            acc_d    = '0;
            dcnt_d   = '0;
            n        = 2'd1;
            r0.kind  = KIND_CONTENT;
            r0.value = simple_escape(char_i);
            bc_d     = bc_inc;
          end
        end
        PH_OCT, PH_HEX: begin
          if ((phase_q == PH_OCT) && is_oct(char_i)) begin
            if (dcnt_q >= 2'd2) begin
              phase_d  = PH_PLAIN;
              acc_d    = '0;
              dcnt_d   = '0;
              n        = 2'd1;
              r0.kind  = KIND_CONTENT;
              r0.value = oct_t[7:0];
              bc_d     = bc_inc;
            end else begin
              acc_d  = oct_t;
              dcnt_d = dcnt_q + 1'b1;
            end
          end else if ((phase_q == PH_HEX) && is_hexd(char_i)) begin
            if (hex_t > 12'd255) begin
              n       = 2'd1;
              r0.kind = KIND_HEX_OVF;
              phase_d = PH_PLAIN;
              acc_d   = '0;
              dcnt_d  = '0;
              bc_d    = '0;
            end else begin
              acc_d = hex_t[AccW-1:0];
            end
          end else begin
            // terminator: flush pending value, then treat byte as plain
            pl       = plain_step(char_i, bc_inc);
            r0.kind  = KIND_CONTENT;
            r0.value = acc_q[7:0];
            r1       = pl.r;
            n        = pl.has ? 2'd2 : 2'd1;
            phase_d  = pl.ph;
            acc_d    = '0;
            dcnt_d   = '0;
            bc_d     = pl.bc;
          end
        end
        PH_HEX0: begin
          if (is_hexd(char_i)) begin
            acc_d   = AccW'(hex_val(char_i));
            phase_d = PH_HEX;
          end else begin
            n       = 2'd1;
            r0.kind = KIND_BAD_HEX;
            phase_d = PH_PLAIN;
            acc_d   = '0;
            dcnt_d  = '0;
            bc_d    = '0;
          end
        end
        default: begin
          r0      = pl.r;
          n       = pl.has ? 2'd1 : 2'd0;
          phase_d = pl.ph;
          bc_d    = pl.bc;
        end
      endcase
    end

    if (n == 2'd1) r0.last = 1'b1;
    if (n == 2'd2) r1.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PLAIN;
      acc_q   <= '0;
      dcnt_q  <= '0;
      bc_q    <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      dcnt_q  <= dcnt_d;
      bc_q    <= bc_d;
    end
  end

  assign push_o.cnt = accept_i ? n : 2'd0;
  assign push_o.r0  = r0;
  assign push_o.r1  = r1;

  a_cnt_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bc_q <= LenW'(MaxLen))
    else $error("byte count above saturation");

  a_two_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n == 2'd2) |-> (!r0.last && r1.last && r0.kind == KIND_CONTENT))
    else $error("second result without content flush");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && n != 2'd0 && r0.kind != KIND_CONTENT) |=>
      (bc_q == '0 && phase_q == PH_PLAIN))
    else $error("end or error did not clear state");

  a_dcnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_OCT) |-> (dcnt_q == 2'd1 || dcnt_q == 2'd2))
    else $error("octal digit count out of range");

endmodule

`default_nettype wire

>>> design/csld_res_fifo.sv
// ----------------------------------------------------------------------------
// csld_res_fifo
// Small result queue: takes up to two results per cycle, hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module csld_res_fifo (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire csld_pkg::push_t           push_i,
  output logic                           space2_o,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output csld_pkg::res_t                 head_o
);
  import csld_pkg::*;

  res_t               mem_q [ResDepth];
  logic [ResPtrW-1:0] wr_q, rd_q;
  logic [ResCntW-1:0] cnt_q, cnt_d;
  logic               pop;

  assign pop      = out_valid_o && out_ready_i;
  assign cnt_d    = cnt_q + ResCntW'(push_i.cnt) - ResCntW'(pop);
  assign space2_o = cnt_q <= ResCntW'(ResDepth - 2);
  assign out_valid_o = cnt_q != '0;
  assign head_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + ResPtrW'(push_i.cnt);
      rd_q  <= rd_q + ResPtrW'(pop);
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) mem_q[wr_q] <= push_i.r0;
    if (push_i.cnt == 2'd2) mem_q[wr_q + 1'b1] <= push_i.r1;
  end

  a_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt != 2'd0) |-> (ResCntW'(push_i.cnt) + cnt_q <= ResCntW'(ResDepth)))
    else $error("result queue overflow");

  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && push_i.cnt == 2'd0) |=> (cnt_q == $past(cnt_q) - 1'b1))
    else $error("count did not drop on pop");

  a_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ResPtrW'(wr_q - rd_q) == cnt_q[ResPtrW-1:0])
    else $error("pointer and count disagree");

endmodule

`default_nettype wire

>>> design/c_string_literal_decoder_unit.sv
// ----------------------------------------------------------------------------
// c_string_literal_decoder_unit
// Streaming decoder of C string literal bodies into content bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o, char_in_i) carries the body bytes
//   of a literal, starting after the opening quote. A zero byte marks end of
//   text. Output channel (out_valid_o / out_ready_i) carries one result per
//   transaction: kind_o, value_o, content_length_o and last_o, which flags the
//   final result caused by a given input byte.
//   Each byte is decoded in the cycle it is accepted and its results (zero,
//   one or two) are written into a 4-entry result queue, which registers
//   them before they reach the output.
//   Throughput: one byte per cycle while the queue has room for two results,
//   as a byte is accepted only then. Bytes that flush an escape and also give
//   a result of their own take two output transactions, which limits the rate
//   only when that happens back to back or when the receiver stalls.
//   Reset puts the decoder in the plain phase with a zero byte count and
//   empties the queue. When the receiver stalls, results stay queued and
//   in_ready_o drops once fewer than two entries are free.
// ----------------------------------------------------------------------------
`default_nettype none

module c_string_literal_decoder_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  char_in_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       kind_o,
  output logic [7:0]       value_o,
  output logic [12:0]      content_length_o,
  output logic             last_o
);
  import csld_pkg::*;

  push_t push;
  res_t  head;
  logic  accept;

  assign accept = in_valid_i && in_ready_o;

  csld_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .char_i   (char_in_i),
    .push_o   (push)
  );

  csld_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space2_o    (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  assign kind_o           = head.kind;
  assign value_o          = head.value;
  assign content_length_o = head.len;
  assign last_o           = head.last;

endmodule

`default_nettype wire

>>> bench/csld_checker.sv
// ----------------------------------------------------------------------------
// csld_checker
// Watches both channels of the string literal decoder, decodes every
// accepted body byte on its own and compares each result with the oldest
// outstanding one.
// ----------------------------------------------------------------------------
`default_nettype none

module csld_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [7:0]  char_in_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [2:0]  kind_i,
  input  wire logic [7:0]  value_i,
  input  wire logic [12:0] content_length_i,
  input  wire logic        last_i,
  output int unsigned      errors_o,
  output int unsigned      outstanding_o,
  output int unsigned      results_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import csld_pkg::*;

  phase_e          phase_q;
  logic [AccW-1:0] acc_q;
  logic [1:0]      ndig_q;
  logic [LenW-1:0] len_q;

  res_t        decoded_q[$];
  res_t        step_res[2];
  int unsigned step_n;
  int unsigned fails = 0;
  int unsigned seen = 0;
  int unsigned waiting = 0;

  assign errors_o      = fails;
  assign outstanding_o = waiting;
  assign results_o     = seen;

  function automatic logic octal_digit(input logic [7:0] c);
    return c[7:3] == 5'b00110;
  endfunction

  // {is digit, nibble}
  function automatic logic [4:0] hex_code(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, c[3:0]};
    if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) return {1'b1, c[3:0] + 4'd9};
    return 5'd0;
  endfunction

  function automatic logic [7:0] unescape(input logic [7:0] c);
    case (c)
      "a": return 8'd7;
      "b": return 8'd8;
      "t": return 8'd9;
      "n": return 8'd10;
      "v": return 8'd11;
      "f": return 8'd12;
      "r": return 8'd13;
      "e": return 8'd27;
      default: return c;
    endcase
  endfunction

  task automatic note(input kind_e k, input logic [7:0] v, input logic [LenW-1:0] l);
    if (step_n < 2) begin
      step_res[step_n].kind  = k;
      step_res[step_n].value = v;
      step_res[step_n].len   = l;
      step_res[step_n].last  = 1'b0;
      step_n++;
    end
  endtask

  task automatic emit_content(input logic [7:0] v);
    note(KIND_CONTENT, v, '0);
    if (len_q < MaxLen) len_q++;
  endtask

  task automatic leave_escape();
    phase_q = PH_PLAIN;
    acc_q   = '0;
    ndig_q  = '0;
  endtask

  task automatic restart();
    leave_escape();
    len_q = '0;
  endtask

  // zero bytes never get here, they are caught before the phase decode
  task automatic plain_char(input logic [7:0] c);
    if (c == "\"") begin
      note(KIND_END, 8'd0, len_q + 1'b1);
      restart();
    end else if (c == "\\") begin
      phase_q = PH_ESC;
    end else begin
      emit_content(c);
    end
  endtask

  task automatic decode_byte(input logic [7:0] c);
    logic [4:0]  hx;
    logic [12:0] grown;
    logic [7:0]  held;
    step_n = 0;
    hx = hex_code(c);
    if (c == 8'h00) begin
      note(KIND_UNCLOSED, 8'd0, '0);
      restart();
    end else begin
      case (phase_q)
        PH_ESC: begin
          if (octal_digit(c)) begin
            acc_q   = {6'd0, c[2:0]};
            ndig_q  = 2'd1;
            phase_q = PH_OCT;
          end else if (c == "x") begin
            acc_q   = '0;
            ndig_q  = '0;
            phase_q = PH_HEX0;
          end else begin
            leave_escape();
            emit_content(unescape(c));
          end
        end
        PH_OCT: begin
          held = acc_q[7:0];
          if (octal_digit(c)) begin
            acc_q  = {acc_q[5:0], c[2:0]};
            ndig_q = ndig_q + 2'd1;
            if (ndig_q == 2'd3) begin
              held = acc_q[7:0];
              leave_escape();
              emit_content(held);
            end
          end else begin
            leave_escape();
            emit_content(held);
            plain_char(c);
          end
        end
        PH_HEX0: begin
          if (hx[4]) begin
            acc_q   = {5'd0, hx[3:0]};
            phase_q = PH_HEX;
          end else begin
            note(KIND_BAD_HEX, 8'd0, '0);
            restart();
          end
        end
        PH_HEX: begin
          if (hx[4]) begin
            grown = {acc_q, 4'h0} + hx[3:0];
            if (grown > 13'd255) begin
              note(KIND_HEX_OVF, 8'd0, '0);
              restart();
            end else begin
              acc_q = grown[AccW-1:0];
            end
          end else begin
            held = acc_q[7:0];
            leave_escape();
            emit_content(held);
            plain_char(c);
          end
        end
        default: plain_char(c);
      endcase
    end
    for (int i = 0; i < step_n; i++) begin
      step_res[i].last = (i == step_n - 1);
      decoded_q.push_back(step_res[i]);
    end
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      restart();
      decoded_q.delete();
      waiting <= 0;
    end else begin
      if (in_valid_i && in_ready_i) decode_byte(char_in_i);
      if (out_valid_i && out_ready_i) begin
        seen++;
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, got kind %0d value %0d len %0d",
                   $time, kind_i, value_i, content_length_i);
          fails++;
        end else begin
          want = decoded_q.pop_front();
          compare_field("kind", want.kind, kind_i);
          compare_field("value", want.value, value_i);
          compare_field("content_length", want.len, content_length_i);
          compare_field("last", want.last, last_i);
        end
      end
      waiting <= decoded_q.size();
    end
  end

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives literal bodies into the string literal decoder: a directed run of
// escape and error cases, then random literals, broken escapes and noise,
// with random stalls on both channels.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import csld_pkg::*;

  localparam int unsigned RandBytes  = 1100;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainWait  = 20;
  localparam int unsigned LongHold   = 200;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  char_in = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  kind;
  logic [7:0]  value;
  logic [12:0] content_length;
  logic        last;

  int unsigned errors, outstanding, results;
  int unsigned bytes_sent = 0;
  int unsigned literals = 0;
  int unsigned cycles = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;

  c_string_literal_decoder_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .char_in_i       (char_in),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .kind_o          (kind),
    .value_o         (value),
    .content_length_o(content_length),
    .last_o          (last)
  );

  csld_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .char_in_i       (char_in),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .kind_i          (kind),
    .value_i         (value),
    .content_length_i(content_length),
    .last_i          (last),
    .errors_o        (errors),
    .outstanding_o   (outstanding),
    .results_o       (results)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LongHold;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 32);
      end
    end
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_byte(input logic [7:0] c);
    in_valid <= 1'b1;
    char_in  <= c;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    bytes_sent++;
    if (!calm) begin
      while ($urandom_range(99) < 32) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
      end
    end
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] plain_pick();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == "\"" || c == "\\");
    return c;
  endfunction

  function automatic logic [7:0] hex_pick(input int unsigned lo);
    int unsigned v;
    v = $urandom_range(lo, 21);
    if (v < 10) return 8'h30 + v[7:0];
    if (v < 16) return 8'h61 + v[7:0] - 8'd10;
    return 8'h41 + v[7:0] - 8'd16;
  endfunction

  function automatic logic is_hex_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  task automatic send_literal();
    int unsigned pick;
    logic [7:0]  c;
    string       simple;
    simple = "abtnvfre";
    repeat ($urandom_range(0, 10)) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        send_byte(plain_pick());
      end else if (pick < 55) begin
        send_byte("\\");
        if ($urandom_range(1)) send_byte(simple[$urandom_range(0, 7)]);
        else send_byte(8'($urandom_range(1, 255)));
      end else if (pick < 72) begin
        send_byte("\\");
        repeat ($urandom_range(1, 3)) begin
          c = 8'h30 + 8'($urandom_range(0, 7));
          send_byte(c);
        end
      end else if (pick < 90) begin
        send_byte("\\");
        send_byte("x");
        repeat ($urandom_range(1, 2)) send_byte(hex_pick(0));
      end else if (pick < 95) begin
        // \x with no digit
        send_byte("\\");
        send_byte("x");
        do c = 8'($urandom_range(1, 255)); while (is_hex_char(c));
        send_byte(c);
      end else begin
        // three digits with a nonzero lead always overflow
        send_byte("\\");
        send_byte("x");
        send_byte(hex_pick(1));
        send_byte(hex_pick(0));
        send_byte(hex_pick(0));
      end
    end
    if ($urandom_range(99) < 90) send_byte("\"");
    else send_byte(8'h00);
    literals++;
  endtask

  initial begin
    int unsigned rand_base;
    bit          held, paused;
    held   = 1'b0;
    paused = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: byte extremes, octal and hex endings, errors, unclosed
    send_byte(8'hff);
    send_text("\"");
    send_text("\\377");
    send_text("\\1\"");
    send_text("\\xAf\\n\"");
    send_text("\\x\"");
    send_text("\\x100");
    send_text("\\5");
    send_byte(8'h00);
    send_byte(8'h00);
    literals += 6;

    rand_base = bytes_sent;
    while (bytes_sent - rand_base < RandBytes) begin
      if (!held && bytes_sent - rand_base >= 300) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      if (!paused && bytes_sent - rand_base >= 650) begin
        wait_drained();
        paused = 1'b1;
      end
      calm = (bytes_sent - rand_base >= 800) && (bytes_sent - rand_base < 950);
      if ($urandom_range(99) < 6) begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_literal();
      end
    end
    calm = 1'b0;

    wait_drained();
    repeat (DrainWait) @(posedge clk_i);

    $display("Sent %0d bytes in %0d literals plus noise, directed escapes and errors first.",
             bytes_sent, literals);
    $display("Checked %0d results across a long output hold-off and a full drain pause.",
             results);
    if (errors == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
